>>> src/uks_pkg.sv
// Package for the unique key stack: command and status codes, controller states,
// default sizes. Used by every file of the block; depends on nothing.
package uks_pkg;

    localparam int DEFAULT_STACK_DEPTH = 16;
    localparam int DATA_W              = 32;
    localparam int COUNT_OUT_W         = 5;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_TOP,
        S_FINISH
    } state_t;

endpackage

>>> src/uks_if.sv
// Handshake channels of the unique key stack: request items and result items.
// Depends on uks_pkg for field widths.
interface uks_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          cmd;
    logic signed [uks_pkg::DATA_W-1:0]   entry_key;
    logic signed [uks_pkg::DATA_W-1:0]   entry_value;

    modport source (output valid, output cmd, output entry_key, output entry_value,
                    input ready);
    modport sink   (input valid, input cmd, input entry_key, input entry_value,
                    output ready);
endinterface

interface uks_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            status;
    logic                                  top_valid;
    logic signed [uks_pkg::DATA_W-1:0]     out_key;
    logic signed [uks_pkg::DATA_W-1:0]     out_value;
    logic [uks_pkg::COUNT_OUT_W-1:0]       entry_count;
    logic                                  is_empty;

    modport source (output valid, output status, output top_valid, output out_key,
                    output out_value, output entry_count, output is_empty,
                    input ready);
    modport sink   (input valid, input status, input top_valid, input out_key,
                    input out_value, input entry_count, input is_empty,
                    output ready);
endinterface

>>> src/uks_mem.sv
// Key and value storage of the unique key stack: one write port, one read port,
// read data registered. Depends on uks_pkg.
module uks_mem #(
    parameter int STACK_DEPTH = uks_pkg::DEFAULT_STACK_DEPTH,
    parameter int ADDR_W      = $clog2(STACK_DEPTH)
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [ADDR_W-1:0]                 waddr,
    input  logic signed [uks_pkg::DATA_W-1:0] wkey,
    input  logic signed [uks_pkg::DATA_W-1:0] wval,
    input  logic                              re,
    input  logic [ADDR_W-1:0]                 raddr,
    output logic signed [uks_pkg::DATA_W-1:0] rkey,
    output logic signed [uks_pkg::DATA_W-1:0] rval
);
    import uks_pkg::*;

    logic signed [DATA_W-1:0] key_mem [STACK_DEPTH];
    logic signed [DATA_W-1:0] val_mem [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr] <= wkey;
            val_mem[waddr] <= wval;
        end
    end

    // hold read data when no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rkey <= key_mem[raddr];
            rval <= val_mem[raddr];
        end
    end

endmodule

>>> src/uks_ctrl.sv
// Sequencer of the unique key stack: key scan, top read, result register.
// Depends on uks_pkg and the channel interfaces in uks_if.sv.
module uks_ctrl #(
    parameter int STACK_DEPTH = uks_pkg::DEFAULT_STACK_DEPTH,
    parameter int ADDR_W      = $clog2(STACK_DEPTH)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    uks_req_if.sink                           req,
    uks_rsp_if.source                         rsp,
    output logic                              mem_we,
    output logic [ADDR_W-1:0]                 mem_waddr,
    output logic signed [uks_pkg::DATA_W-1:0] mem_wkey,
    output logic signed [uks_pkg::DATA_W-1:0] mem_wval,
    output logic                              mem_re,
    output logic [ADDR_W-1:0]                 mem_raddr,
    input  logic signed [uks_pkg::DATA_W-1:0] mem_rkey,
    input  logic signed [uks_pkg::DATA_W-1:0] mem_rval
);
    import uks_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    state_t                   state_reg, state_next;
    logic [1:0]               cmd_reg, cmd_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [CW-1:0]            fill_reg, fill_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic                     pend_reg, pend_next;
    logic                     dup_reg, dup_next;
    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               status_reg, status_next;
    logic                     top_valid_reg, top_valid_next;
    logic signed [DATA_W-1:0] out_key_reg, out_key_next;
    logic signed [DATA_W-1:0] out_val_reg, out_val_next;
    logic [CW-1:0]            count_reg, count_next;

    logic [CW-1:0]            last_idx;
    logic                     key_match;
    logic                     is_full;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    assign last_idx  = fill_reg - CW'(1);
    assign key_match = (mem_rkey == key_reg);
    assign is_full   = (fill_reg == CW'(STACK_DEPTH));
    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        dup_next       = dup_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        top_valid_next = top_valid_reg;
        out_key_next   = out_key_reg;
        out_val_next   = out_val_reg;
        count_next     = count_reg;
        mem_we         = 1'b0;
        mem_waddr      = ADDR_W'(fill_reg);
        mem_wkey       = key_reg;
        mem_wval       = val_reg;
        mem_re         = 1'b0;
        mem_raddr      = idx_reg;
        req.ready      = (state_reg == S_IDLE);

        // drop the result once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next  = req.cmd;
                    key_next  = req.entry_key;
                    val_next  = req.entry_value;
                    idx_next  = '0;
                    pend_next = 1'b0;
                    dup_next  = 1'b0;
                    if (fill_reg == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (req.cmd == CMD_PUSH)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (req.cmd == CMD_POP || req.cmd == CMD_QUERY)
                    begin
                        state_next = S_TOP;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                // read one stored key a cycle, compare the one read last cycle
                mem_re    = 1'b1;
                mem_raddr = idx_reg;
                pend_next = 1'b1;
                if (pend_reg && key_match)
                begin
                    dup_next = 1'b1;
                end
                if (CW'(idx_reg) == last_idx)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            S_LAST:
            begin
                if (key_match)
                begin
                    dup_next = 1'b1;
                end
                state_next = S_FINISH;
            end
            S_TOP:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ADDR_W'(last_idx);
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    status_next    = ST_OK;
                    top_valid_next = 1'b0;
                    out_key_next   = '0;
                    out_val_next   = '0;
                    if (cmd_reg == CMD_PUSH)
                    begin
                        if (dup_reg)
                        begin
                            status_next = ST_DUP;
                        end
                        else if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            fill_next = fill_reg + CW'(1);
                        end
                    end
                    else if (cmd_reg == CMD_POP || cmd_reg == CMD_QUERY)
                    begin
                        if (fill_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            top_valid_next = 1'b1;
                            out_key_next   = mem_rkey;
                            out_val_next   = mem_rval;
                            if (cmd_reg == CMD_POP)
                            begin
                                fill_next = last_idx;
                            end
                        end
                    end
                    count_next     = fill_next;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            dup_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            dup_reg       <= dup_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        status_reg    <= status_next;
        top_valid_reg <= top_valid_next;
        out_key_reg   <= out_key_next;
        out_val_reg   <= out_val_next;
        count_reg     <= count_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.top_valid   = top_valid_reg;
    assign rsp.out_key     = out_key_reg;
    assign rsp.out_value   = out_val_reg;
    assign rsp.entry_count = count_ext[COUNT_OUT_W-1:0];
    assign rsp.is_empty    = (count_reg == '0);

endmodule

>>> src/unique_key_stack.sv
// Top level of the unique key stack: storage memory plus sequencer.
// Depends on uks_pkg, uks_if.sv, uks_mem and uks_ctrl.
//
// Usage:
//   req carries one command item (cmd, entry_key, entry_value); rsp returns
//   exactly one result item per command (status, top_valid, out_key,
//   out_value, entry_count, is_empty), in command order.
//   Push compares its key against every stored key, reading the key memory
//   one entry per cycle, then writes the pair on top unless the key is a
//   duplicate or the stack is full. Pop and query read the top entry.
// Sequence (from req accept to rsp valid):
//   push on a stack holding N pairs: N key reads, last compare, result
//   load; pop or query: top read, result load; any command on an empty
//   stack and the unused code: result load only. One item at a time:
//   req.ready rises again the cycle after the result is loaded, so no new
//   item is accepted while a push scans; the scan is paced by the single
//   read port of the key memory.
// Reset: the count clears and the stack is empty at once; memory contents
//   are not cleared, since only entries below the count are ever read.
// Stall: the result register holds while rsp.ready is low; a new item may
//   be accepted and worked on meanwhile, and it waits at result load.
module unique_key_stack #(
    parameter int STACK_DEPTH = uks_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    uks_req_if.sink   req,
    uks_rsp_if.source rsp
);
    import uks_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic signed [DATA_W-1:0] mem_wkey;
    logic signed [DATA_W-1:0] mem_wval;
    logic                     mem_re;
    logic [ADDR_W-1:0]        mem_raddr;
    logic signed [DATA_W-1:0] mem_rkey;
    logic signed [DATA_W-1:0] mem_rval;

    // Writes happen only at result load and reads only in later items, so a
    // read never overlaps a write to the same entry.
    uks_mem #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wkey  (mem_wkey),
        .wval  (mem_wval),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rkey  (mem_rkey),
        .rval  (mem_rval)
    );

    uks_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wkey  (mem_wkey),
        .mem_wval  (mem_wval),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rkey  (mem_rkey),
        .mem_rval  (mem_rval)
    );

endmodule

>>> sim/unique_key_stack_tb.sv
`timescale 1ns / 100ps
// Testbench for unique_key_stack: drives push, pop and query items through the request
// channel and checks every result item against a behavioral stack model.
// Depends on uks_pkg, the uks_req_if/uks_rsp_if interfaces and the unique_key_stack RTL.
module unique_key_stack_tb;
    import uks_pkg::*;

    localparam int DEPTH = DEFAULT_STACK_DEPTH;
    // Code 3 is not an operation; the block must answer it with a plain ok.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int ITEMS_PER_PHASE = 225;
    localparam int KEY_POOL_SIZE   = 24;
    localparam int HOLD_LEN        = 300;   // long receiver hold-off, in cycles
    localparam int DRAIN_CYCLES    = 40;    // well above the worst push latency
    localparam int STALL_LIMIT     = 2000;  // cycles with no item moving on either side

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } stack_cmd_t;

    typedef struct packed {
        logic [1:0]               status;
        logic                     top_valid;
        logic signed [DATA_W-1:0] out_key;
        logic signed [DATA_W-1:0] out_value;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic                     is_empty;
    } stack_result_t;

    logic clk = 1'b0;
    logic rst_n;

    uks_req_if req ();
    uks_rsp_if rsp ();

    unique_key_stack #(
        .STACK_DEPTH(DEPTH)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    always #2 clk = ~clk;

    // Commands waiting to be offered, and results owed by the block in order.
    stack_cmd_t    pending_cmds[$];
    stack_result_t expected_results[$];

    // Shadow of the stack contents, advanced once per accepted command.
    logic signed [DATA_W-1:0] model_keys[DEPTH];
    logic signed [DATA_W-1:0] model_values[DEPTH];
    int                       model_fill = 0;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  pressure_on    = 1'b0;
    bit  long_hold;
    int  hold_cycles;
    int  idle_cycles    = 0;
    int  mismatches     = 0;
    int  results_seen   = 0;

    stack_cmd_t    offered;
    stack_result_t got;
    stack_result_t want;

    logic signed [DATA_W-1:0] key_pool[KEY_POOL_SIZE];

    // Apply one command to the shadow stack and return the result it owes.
    // The key check comes before the full check, so a duplicate on a full
    // stack still reports a duplicate.
    function automatic stack_result_t apply_stack_op(stack_cmd_t c);
        stack_result_t r;
        bit            hit;
        r   = '0;
        hit = 1'b0;
        case (c.cmd) inside
            CMD_PUSH:
            begin
                for (int i = 0; i < model_fill; i++)
                begin
                    if (model_keys[i] == c.key)
                        hit = 1'b1;
                end
                if (hit)
                    r.status = ST_DUP;
                else if (model_fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    model_keys[model_fill]   = c.key;
                    model_values[model_fill] = c.value;
                    model_fill++;
                end
            end
            CMD_POP, CMD_QUERY:
            begin
                if (model_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.top_valid = 1'b1;
                    r.out_key   = model_keys[model_fill - 1];
                    r.out_value = model_values[model_fill - 1];
                    if (c.cmd == CMD_POP)
                        model_fill--;
                end
            end
            default:
            begin
                // unused code: no operation, status stays ok
            end
        endcase
        r.entry_count = COUNT_OUT_W'(model_fill);
        r.is_empty    = (model_fill == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got_v,
                                   input logic [DATA_W-1:0] want_v);
        mismatches++;
        $display("%0t: result %0d: %s got 0x%0h, expected 0x%0h",
                 $realtime, results_seen, what, got_v, want_v);
    endtask

    task automatic add_cmd(input logic [1:0] cmd, input logic [DATA_W-1:0] key,
                           input logic [DATA_W-1:0] value);
        stack_cmd_t c;
        c.cmd   = cmd;
        c.key   = key;
        c.value = value;
        pending_cmds.push_back(c);
    endtask

    // Driver: predict on every accepted item, then offer the next one or idle.
    // An offered item holds until the block takes it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid       <= 1'b0;
            req.cmd         <= CMD_PUSH;
            req.entry_key   <= '0;
            req.entry_value <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_results.push_back(apply_stack_op(offered));
            if (!req.valid || req.ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered          = pending_cmds.pop_front();
                    req.valid       <= 1'b1;
                    req.cmd         <= offered.cmd;
                    req.entry_key   <= offered.key;
                    req.entry_value <= offered.value;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation,
    // field by field, then pick the next ready level.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                got.status      = rsp.status;
                got.top_valid   = rsp.top_valid;
                got.out_key     = rsp.out_key;
                got.out_value   = rsp.out_value;
                got.entry_count = rsp.entry_count;
                got.is_empty    = rsp.is_empty;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, status", DATA_W'(got.status), '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", DATA_W'(got.status),
                                        DATA_W'(want.status));
                    if (got.top_valid !== want.top_valid)
                        report_mismatch("top_valid", DATA_W'(got.top_valid),
                                        DATA_W'(want.top_valid));
                    if (got.out_key !== want.out_key)
                        report_mismatch("out_key", got.out_key, want.out_key);
                    if (got.out_value !== want.out_value)
                        report_mismatch("out_value", got.out_value, want.out_value);
                    if (got.entry_count !== want.entry_count)
                        report_mismatch("entry_count", DATA_W'(got.entry_count),
                                        DATA_W'(want.entry_count));
                    if (got.is_empty !== want.is_empty)
                        report_mismatch("is_empty", DATA_W'(got.is_empty),
                                        DATA_W'(want.is_empty));
                end
            end
            rsp.ready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, run once when the pressure phase starts. The
    // sender keeps offering, so the block fills its result slot and then
    // drops req.ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
            long_hold   <= 1'b0;
        end
        else if (pressure_on && hold_cycles < HOLD_LEN)
        begin
            hold_cycles <= hold_cycles + 1;
            long_hold   <= 1'b1;
        end
        else
            long_hold <= 1'b0;
    end

    // Count cycles in which no item moves on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("%0t: no item moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("unique_key_stack_tb: FAIL");
        $finish;
    end

    initial
    begin
        int          send_tbl[4];
        int          recv_tbl[4];
        int          push_pct;
        int          roll;
        logic [1:0]  op;
        logic [31:0] k;

        // Phases: no idling, sender idling, receiver stalling, both.
        send_tbl = '{0, 70, 0, 28};
        recv_tbl = '{0, 0, 70, 28};
        push_pct = 50;

        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.cmd         = CMD_PUSH;
        req.entry_key   = '0;
        req.entry_value = '0;
        rsp.ready       = 1'b0;

        // Seed the pool with the key extremes; the rest are random. Reuse of
        // pool keys makes duplicates common, and its size beats the depth.
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // Directed part: empty stack first.
        add_cmd(CMD_POP, 32'h1234_5678, 32'h9ABC_DEF0);
        add_cmd(CMD_QUERY, '0, '0);
        add_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Push the extremes of key and value.
        add_cmd(CMD_PUSH, 32'h8000_0000, 32'h7FFF_FFFF);
        add_cmd(CMD_PUSH, 32'h7FFF_FFFF, 32'h8000_0000);
        add_cmd(CMD_PUSH, 32'h0000_0000, 32'h0000_0000);
        add_cmd(CMD_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Duplicate of the bottom key, then read back and remove the top.
        add_cmd(CMD_PUSH, 32'h8000_0000, 32'h5555_5555);
        add_cmd(CMD_QUERY, '0, '0);
        add_cmd(CMD_POP, '0, '0);
        add_cmd(CMD_UNUSED, 32'hAAAA_AAAA, 32'h5555_5555);
        // Fill to the top, then push a new key and a duplicate on a full stack.
        for (int i = 0; i < DEPTH - 3; i++)
            add_cmd(CMD_PUSH, 32'h1000_0000 + i, 32'hA5A5_0000 + i);
        add_cmd(CMD_PUSH, 32'h2222_2222, 32'h3333_3333);
        add_cmd(CMD_PUSH, 32'h7FFF_FFFF, 32'h0000_0001);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  <= send_tbl[p];
            recv_stall_pct <= recv_tbl[p];
            if (p == 0)
                pressure_on <= 1'b1;
            // Pick fill-heavy or drain-heavy stretches at random so the stack
            // keeps crossing between empty and full.
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 24 == 0)
                    push_pct = ($urandom_range(1) == 1) ? 80 : 25;
                roll = $urandom_range(99);
                if (roll < 4)
                    op = CMD_UNUSED;
                else if (roll < 14)
                    op = CMD_QUERY;
                else if (roll < 14 + push_pct * 86 / 100)
                    op = CMD_PUSH;
                else
                    op = CMD_POP;
                roll = $urandom_range(9);
                if (roll < 7)
                    k = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
                else
                    k = $urandom;
                add_cmd(op, k, $urandom);
            end
            while (pending_cmds.size() != 0)
                @(posedge clk);
        end

        // Drain: wait for the last results, then a margin for stray ones.
        while (req.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("unique_key_stack_tb: PASS");
        else
            $display("unique_key_stack_tb: FAIL");
        $finish;
    end

endmodule
